// ===== sv/keystroke_script_parser_assert.svh =====
// assertion helpers for the keystroke script parser
`ifndef KEYSTROKE_SCRIPT_PARSER_ASSERT_SVH
`define KEYSTROKE_SCRIPT_PARSER_ASSERT_SVH

// checked only while out of reset
`define KSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define KSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/ksp_pkg.sv =====
`default_nettype none

package ksp_pkg;

  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_VT    = 8'd11;
  localparam logic [7:0] CHAR_FF    = 8'd12;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  localparam logic [7:0]  TOKEN_GAP_RESET = 8'd5;
  localparam logic [15:0] DELAY_MAX       = 16'hFFFF;

  localparam logic [2:0] ACT_PRESS_CHAR = 3'd0;
  localparam logic [2:0] ACT_PRESS_KEY  = 3'd1;
  localparam logic [2:0] ACT_TYPE_CHAR  = 3'd2;
  localparam logic [2:0] ACT_WAIT       = 3'd3;
  localparam logic [2:0] ACT_SET_DEFAULT_DELAY = 3'd4;
  localparam logic [2:0] ACT_RELEASE_ALL = 3'd5;

  // names are right-justified strings, first char in the highest used byte
  typedef logic [95:0] name_t;

  localparam name_t      KW_STRING           = "STRING";
  localparam logic [3:0] KW_STRING_LEN       = 4'd6;
  localparam name_t      KW_DELAY            = "DELAY";
  localparam logic [3:0] KW_DELAY_LEN        = 4'd5;
  localparam name_t      KW_DEFAULTDELAY     = "DEFAULTDELAY";
  localparam logic [3:0] KW_DEFAULTDELAY_LEN = 4'd12;
  localparam name_t      KW_REM              = "REM";
  localparam logic [3:0] KW_REM_LEN          = 4'd3;

  localparam int KEY_COUNT = 34;

  typedef struct packed {
    name_t      name;
    logic [3:0] len;
    logic [4:0] id;
  } key_entry_t;

  typedef struct packed {
    logic       is_string;
    logic       is_delay;
    logic       is_defdelay;
    logic       is_rem;
    logic       key_hit;
    logic [4:0] key_id;
  } word_match_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  char_code;
    logic [4:0]  named_key;
    logic [15:0] delay_ms;
    logic        last;
  } result_t;

  function automatic key_entry_t key_entry(input logic [5:0] idx);
    key_entry_t e;
    case (idx)
      6'd0:  e = '{"ENTER",      4'd5,  5'd0};
      6'd1:  e = '{"CTRL",       4'd4,  5'd1};
      6'd2:  e = '{"SHIFT",      4'd5,  5'd2};
      6'd3:  e = '{"ALT",        4'd3,  5'd3};
      6'd4:  e = '{"GUI",        4'd3,  5'd4};
      6'd5:  e = '{"UP",         4'd2,  5'd5};
      6'd6:  e = '{"UPARROW",    4'd7,  5'd5};
      6'd7:  e = '{"DOWN",       4'd4,  5'd6};
      6'd8:  e = '{"DOWNARROW",  4'd9,  5'd6};
      6'd9:  e = '{"LEFT",       4'd4,  5'd7};
      6'd10: e = '{"LEFTARROW",  4'd9,  5'd7};
      6'd11: e = '{"RIGHT",      4'd5,  5'd8};
      6'd12: e = '{"RIGHTARROW", 4'd10, 5'd8};
      6'd13: e = '{"DELETE",     4'd6,  5'd9};
      6'd14: e = '{"PAGEUP",     4'd6,  5'd10};
      6'd15: e = '{"PAGEDOWN",   4'd8,  5'd11};
      6'd16: e = '{"HOME",       4'd4,  5'd12};
      6'd17: e = '{"ESC",        4'd3,  5'd13};
      6'd18: e = '{"INSERT",     4'd6,  5'd14};
      6'd19: e = '{"TAB",        4'd3,  5'd15};
      6'd20: e = '{"END",        4'd3,  5'd16};
      6'd21: e = '{"CAPSLOCK",   4'd8,  5'd17};
      6'd22: e = '{"F1",         4'd2,  5'd18};
      6'd23: e = '{"F2",         4'd2,  5'd19};
      6'd24: e = '{"F3",         4'd2,  5'd20};
      6'd25: e = '{"F4",         4'd2,  5'd21};
      6'd26: e = '{"F5",         4'd2,  5'd22};
      6'd27: e = '{"F6",         4'd2,  5'd23};
      6'd28: e = '{"F7",         4'd2,  5'd24};
      6'd29: e = '{"F8",         4'd2,  5'd25};
      6'd30: e = '{"F9",         4'd2,  5'd26};
      6'd31: e = '{"F10",        4'd3,  5'd27};
      6'd32: e = '{"F11",        4'd3,  5'd28};
      6'd33: e = '{"F12",        4'd3,  5'd29};
      // never matches: no word has length 15 with this name
      default: e = '{'0, 4'd15, 5'd0};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ksp_word_match.sv =====
`default_nettype none

module ksp_word_match #(
  parameter int WORD_CHARS = 12,
  localparam int LEN_W = $clog2(WORD_CHARS + 1)
) (
  input  wire logic [WORD_CHARS-1:0][7:0] word_chars,
  input  wire logic [LEN_W-1:0]           word_length,
  input  wire logic                       word_overflow,
  output ksp_pkg::word_match_t            match
);

  function automatic logic word_is(input ksp_pkg::name_t name, input logic [3:0] len);
    logic ok;
    ok = !word_overflow && (word_length == LEN_W'(len));
    for (int i = 0; i < WORD_CHARS; i++) begin
      if (i < int'(len)) begin
        if (word_chars[i] != name[8*(int'(len)-1-i) +: 8]) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  always_comb begin : match_logic
    ksp_pkg::key_entry_t ent;
    match = '0;
    match.is_string   = word_is(ksp_pkg::KW_STRING, ksp_pkg::KW_STRING_LEN);
    match.is_delay    = word_is(ksp_pkg::KW_DELAY, ksp_pkg::KW_DELAY_LEN);
    match.is_defdelay = word_is(ksp_pkg::KW_DEFAULTDELAY, ksp_pkg::KW_DEFAULTDELAY_LEN);
    match.is_rem      = word_is(ksp_pkg::KW_REM, ksp_pkg::KW_REM_LEN);
    for (int k = 0; k < ksp_pkg::KEY_COUNT; k++) begin
      ent = ksp_pkg::key_entry(6'(k));
      if (word_is(ent.name, ent.len)) begin
        match.key_hit = 1'b1;
        match.key_id  = match.key_id | ent.id;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/keystroke_script_parser.sv =====
// Keystroke script parser.
// Input channel (in_valid/in_ready): one script byte per beat, with
// in_end_of_script marking the end of the script (byte ignored, acts as a
// final line end). Carriage returns give no results.
// Output channel (out_valid/out_ready): zero to three action beats per input
// beat, in order; out_last marks the final action of that input byte.
// Configuration: cfg_wr_en/cfg_wr_data load the per-token gap in ms; write
// only while the block is idle.
// Results of a byte are registered and appear the cycle after it is accepted.
// Throughput: one input byte per cycle while each byte gives at most one
// action and out_ready is high; a byte giving more actions holds the input
// while the three-entry result buffer drains, one beat per ready cycle.
// A new byte is taken in the same cycle the last buffered beat is taken.
// When the receiver stalls, the buffer holds its beats and in_ready stays
// low while any of them is waiting.
// Reset (rst_n low, synchronous) empties the buffer, restores the gap to 5 ms
// and puts the parser at the start of a line.
`default_nettype none

`include "keystroke_script_parser_assert.svh"

module keystroke_script_parser #(
  parameter int WORD_CHARS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_script_byte,
  input  wire logic        in_end_of_script,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_action,
  output logic [7:0]       out_char_code,
  output logic [4:0]       out_named_key,
  output logic [15:0]      out_delay_ms,
  output logic             out_last
);

  localparam int IDX_W = $clog2(WORD_CHARS);
  localparam int LEN_W = $clog2(WORD_CHARS + 1);

  localparam logic [2:0] MODE_FIRST    = 3'd0;
  localparam logic [2:0] MODE_KEYS     = 3'd1;
  localparam logic [2:0] MODE_TYPE     = 3'd2;
  localparam logic [2:0] MODE_DELAY    = 3'd3;
  localparam logic [2:0] MODE_DEFDELAY = 3'd4;
  localparam logic [2:0] MODE_REM      = 3'd5;

  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  logic [7:0]                  token_gap_r;
  logic [2:0]                  parse_mode_r, parse_mode_nxt;
  logic [WORD_CHARS-1:0][7:0]  word_chars_r;
  logic [LEN_W-1:0]            word_length_r, word_length_nxt;
  logic                        word_overflow_r, word_overflow_nxt;
  logic [15:0]                 number_value_r, number_value_nxt;
  logic [1:0]                  number_phase_r, number_phase_nxt;
  logic                        number_negative_r, number_negative_nxt;
  ksp_pkg::result_t            res_r [3];
  ksp_pkg::result_t            res_nxt [3];
  logic [1:0]                  cnt_r, cnt_nxt;

  ksp_pkg::word_match_t        match;
  ksp_pkg::result_t            res_a, res_b, res_c;
  ksp_pkg::result_t            slot [3];
  logic                        a_en, b_en, c_en;
  logic [1:0]                  n_res;
  logic                        word_wr;
  logic                        in_acc;
  logic                        line_end;
  logic                        is_digit;
  logic                        press_en;
  logic [19:0]                 num_acc;
  logic [15:0]                 num_sat;

  ksp_word_match #(
    .WORD_CHARS(WORD_CHARS)
  ) u_match (
    .word_chars   (word_chars_r),
    .word_length  (word_length_r),
    .word_overflow(word_overflow_r),
    .match        (match)
  );

  assign in_ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign in_acc   = in_valid && in_ready;
  assign line_end = in_end_of_script || (in_script_byte == ksp_pkg::CHAR_LF);
  assign is_digit = (in_script_byte >= ksp_pkg::CHAR_ZERO) &&
                    (in_script_byte <= ksp_pkg::CHAR_NINE);
  assign press_en = !word_overflow_r && (word_length_r != '0) &&
                    ((word_length_r == LEN_W'(1)) || match.key_hit);

  // decimal accumulate with saturation
  assign num_acc = 20'(number_value_r) * 20'd10 + 20'(in_script_byte[3:0]);
  assign num_sat = (num_acc > 20'(ksp_pkg::DELAY_MAX)) ? ksp_pkg::DELAY_MAX : num_acc[15:0];

  always_comb begin
    res_a = '0;
    if (word_length_r == LEN_W'(1)) begin
      res_a.action    = ksp_pkg::ACT_PRESS_CHAR;
      res_a.char_code = word_chars_r[0];
    end else begin
      res_a.action    = ksp_pkg::ACT_PRESS_KEY;
      res_a.named_key = match.key_id;
    end
    res_c        = '0;
    res_c.action = ksp_pkg::ACT_RELEASE_ALL;
  end

  always_comb begin
    parse_mode_nxt      = parse_mode_r;
    word_length_nxt     = word_length_r;
    word_overflow_nxt   = word_overflow_r;
    number_value_nxt    = number_value_r;
    number_phase_nxt    = number_phase_r;
    number_negative_nxt = number_negative_r;
    word_wr             = 1'b0;
    a_en                = 1'b0;
    b_en                = 1'b0;
    c_en                = 1'b0;
    res_b               = '0;
    res_b.action        = ksp_pkg::ACT_WAIT;
    res_b.delay_ms      = {8'd0, token_gap_r};

    if (in_acc && (in_end_of_script || (in_script_byte != ksp_pkg::CHAR_CR))) begin
      case (parse_mode_r)
        MODE_FIRST, MODE_KEYS: begin
          if (line_end) begin
            if (parse_mode_r == MODE_FIRST) begin
              a_en = press_en;
            end else if ((word_length_r != '0) || word_overflow_r) begin
              a_en = press_en;
              b_en = 1'b1;
            end
          end else if (in_script_byte == ksp_pkg::CHAR_SPACE) begin
            if (parse_mode_r == MODE_FIRST && match.is_string) begin
              parse_mode_nxt = MODE_TYPE;
            end else if (parse_mode_r == MODE_FIRST &&
                         (match.is_delay || match.is_defdelay)) begin
              parse_mode_nxt      = match.is_delay ? MODE_DELAY : MODE_DEFDELAY;
              number_value_nxt    = '0;
              number_phase_nxt    = PH_SKIP;
              number_negative_nxt = 1'b0;
            end else if (parse_mode_r == MODE_FIRST && match.is_rem) begin
              parse_mode_nxt = MODE_REM;
            end else begin
              a_en           = press_en;
              b_en           = 1'b1;
              parse_mode_nxt = MODE_KEYS;
            end
            word_length_nxt   = '0;
            word_overflow_nxt = 1'b0;
          end else if (word_length_r < LEN_W'(WORD_CHARS)) begin
            word_wr         = 1'b1;
            word_length_nxt = word_length_r + LEN_W'(1);
          end else begin
            word_overflow_nxt = 1'b1;
          end
        end
        MODE_TYPE: begin
          if (!line_end) begin
            b_en            = 1'b1;
            res_b.action    = ksp_pkg::ACT_TYPE_CHAR;
            res_b.char_code = in_script_byte;
            res_b.delay_ms  = '0;
          end
        end
        MODE_DELAY, MODE_DEFDELAY: begin
          if (line_end) begin
            b_en           = 1'b1;
            res_b.action   = (parse_mode_r == MODE_DELAY) ? ksp_pkg::ACT_WAIT :
                                                            ksp_pkg::ACT_SET_DEFAULT_DELAY;
            res_b.delay_ms = number_negative_r ? '0 : number_value_r;
          end else begin
            case (number_phase_r)
              PH_SKIP: begin
                if (in_script_byte == ksp_pkg::CHAR_TAB || in_script_byte == ksp_pkg::CHAR_VT ||
                    in_script_byte == ksp_pkg::CHAR_FF ||
                    in_script_byte == ksp_pkg::CHAR_SPACE) begin
                  number_phase_nxt = PH_SKIP;
                end else if (in_script_byte == ksp_pkg::CHAR_MINUS ||
                             in_script_byte == ksp_pkg::CHAR_PLUS) begin
                  number_negative_nxt = (in_script_byte == ksp_pkg::CHAR_MINUS);
                  number_phase_nxt    = PH_DIGITS;
                end else if (is_digit) begin
                  number_phase_nxt = PH_DIGITS;
                  number_value_nxt = num_sat;
                end else begin
                  number_phase_nxt = PH_DONE;
                end
              end
              PH_DIGITS: begin
                if (is_digit) begin
                  number_value_nxt = num_sat;
                end else begin
                  number_phase_nxt = PH_DONE;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase

      if (line_end) begin
        c_en              = 1'b1;
        parse_mode_nxt    = MODE_FIRST;
        word_length_nxt   = '0;
        word_overflow_nxt = 1'b0;
      end
    end
  end

  // pack enabled results in order and mark the final one
  always_comb begin
    n_res   = 2'(a_en) + 2'(b_en) + 2'(c_en);
    slot[0] = a_en ? res_a : (b_en ? res_b : res_c);
    slot[1] = a_en ? (b_en ? res_b : res_c) : res_c;
    slot[2] = res_c;
    for (int i = 0; i < 3; i++) begin
      slot[i].last = (2'(i) == n_res - 2'd1);
    end

    res_nxt = res_r;
    cnt_nxt = cnt_r;
    if (in_acc) begin
      res_nxt = slot;
      cnt_nxt = n_res;
    end else if (out_valid && out_ready) begin
      res_nxt[0] = res_r[1];
      res_nxt[1] = res_r[2];
      cnt_nxt    = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_gap_r       <= ksp_pkg::TOKEN_GAP_RESET;
      parse_mode_r      <= MODE_FIRST;
      word_length_r     <= '0;
      word_overflow_r   <= 1'b0;
      number_value_r    <= '0;
      number_phase_r    <= PH_SKIP;
      number_negative_r <= 1'b0;
      cnt_r             <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        token_gap_r <= cfg_wr_data;
      end
      parse_mode_r      <= parse_mode_nxt;
      word_length_r     <= word_length_nxt;
      word_overflow_r   <= word_overflow_nxt;
      number_value_r    <= number_value_nxt;
      number_phase_r    <= number_phase_nxt;
      number_negative_r <= number_negative_nxt;
      cnt_r             <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (word_wr) begin
      word_chars_r[word_length_r[IDX_W-1:0]] <= in_script_byte;
    end
  end

  assign out_valid     = (cnt_r != 2'd0);
  assign out_action    = res_r[0].action;
  assign out_char_code = res_r[0].char_code;
  assign out_named_key = res_r[0].named_key;
  assign out_delay_ms  = res_r[0].delay_ms;
  assign out_last      = res_r[0].last;

  `KSP_ASSERT(a_more_after_not_last,
              out_valid && out_ready && !out_last |=> out_valid,
              "beat without last mark not followed by another")
  `KSP_ASSERT(a_full_ends_last, cnt_r == 2'd3 |-> res_r[2].last,
              "third buffered beat lacks last mark")
  `KSP_ASSERT(a_line_end_resets,
              in_acc && line_end |=> parse_mode_r == MODE_FIRST && word_length_r == '0,
              "line end did not restart line")
  `KSP_ASSERT(a_type_no_word,
              parse_mode_r == MODE_TYPE |-> word_length_r == '0 && !word_overflow_r,
              "word held while typing")
  `KSP_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> cnt_r == 2'd0,
                     "result buffer not empty after reset")

endmodule

`default_nettype wire

// ===== sim/tb_keystroke_script_parser.sv =====
`timescale 1ns / 1ps

localparam int PARSER_WORD_CHARS = 12;

typedef enum logic [2:0] {
  PM_FIRST, PM_KEYS, PM_TYPE, PM_DELAY, PM_DEFDELAY, PM_REM
} parse_mode_e;

typedef enum logic [1:0] {NUM_SKIP, NUM_DIGITS, NUM_DONE} num_phase_e;

class action_scoreboard;
  logic [7:0]       gap_ms;
  parse_mode_e      mode;
  logic [7:0]       word [PARSER_WORD_CHARS];
  int               word_len;
  bit               word_ovf;
  int unsigned      num_value;
  num_phase_e       num_phase;
  bit               num_neg;
  string            key_names[$];
  int               key_ids[$];
  ksp_pkg::result_t step_q[$];
  ksp_pkg::result_t expected_q[$];
  int unsigned      errors;

  function new();
    key_names = '{"ENTER", "CTRL", "SHIFT", "ALT", "GUI", "UP", "UPARROW", "DOWN",
                  "DOWNARROW", "LEFT", "LEFTARROW", "RIGHT", "RIGHTARROW", "DELETE",
                  "PAGEUP", "PAGEDOWN", "HOME", "ESC", "INSERT", "TAB", "END",
                  "CAPSLOCK", "F1", "F2", "F3", "F4", "F5", "F6", "F7", "F8", "F9",
                  "F10", "F11", "F12"};
    key_ids = '{0, 1, 2, 3, 4, 5, 5, 6, 6, 7, 7, 8, 8, 9, 10, 11, 12, 13, 14, 15, 16,
                17, 18, 19, 20, 21, 22, 23, 24, 25, 26, 27, 28, 29};
    gap_ms = ksp_pkg::TOKEN_GAP_RESET;
    mode = PM_FIRST;
    word_len = 0;
    word_ovf = 0;
    num_value = 0;
    num_phase = NUM_SKIP;
    num_neg = 0;
    errors = 0;
  endfunction

  function bit word_is(string name);
    if (word_ovf || name.len() != word_len) return 0;
    for (int i = 0; i < word_len; i++)
      if (word[i] != name[i]) return 0;
    return 1;
  endfunction

  function void push(logic [2:0] act, logic [7:0] chr, logic [4:0] key, logic [15:0] ms);
    ksp_pkg::result_t r;
    r.action = act;
    r.char_code = chr;
    r.named_key = key;
    r.delay_ms = ms;
    r.last = 1'b0;
    step_q.push_back(r);
  endfunction

  function void clear_word();
    word_len = 0;
    word_ovf = 0;
  endfunction

  function void add_char(logic [7:0] c);
    if (word_len < PARSER_WORD_CHARS) begin
      word[word_len] = c;
      word_len++;
    end else begin
      word_ovf = 1;
    end
  endfunction

  function void press_word();
    if (word_ovf || word_len == 0) return;
    if (word_len == 1) begin
      push(ksp_pkg::ACT_PRESS_CHAR, word[0], 5'd0, 16'd0);
      return;
    end
    foreach (key_names[i])
      if (word_is(key_names[i])) begin
        push(ksp_pkg::ACT_PRESS_KEY, 8'd0, 5'(key_ids[i]), 16'd0);
        return;
      end
  endfunction

  function void press_with_gap();
    press_word();
    push(ksp_pkg::ACT_WAIT, 8'd0, 5'd0, {8'd0, gap_ms});
  endfunction

  function void start_number(parse_mode_e m);
    mode = m;
    num_value = 0;
    num_phase = NUM_SKIP;
    num_neg = 0;
  endfunction

  function void digest_number(logic [7:0] b);
    bit digit;
    digit = (b >= ksp_pkg::CHAR_ZERO && b <= ksp_pkg::CHAR_NINE);
    if (num_phase == NUM_SKIP) begin
      if (b == ksp_pkg::CHAR_TAB || b == ksp_pkg::CHAR_VT ||
          b == ksp_pkg::CHAR_FF || b == ksp_pkg::CHAR_SPACE) return;
      if (b == ksp_pkg::CHAR_MINUS || b == ksp_pkg::CHAR_PLUS) begin
        num_neg = (b == ksp_pkg::CHAR_MINUS);
        num_phase = NUM_DIGITS;
        return;
      end
      num_phase = digit ? NUM_DIGITS : NUM_DONE;
    end else if (num_phase == NUM_DIGITS && !digit) begin
      num_phase = NUM_DONE;
    end
    if (num_phase == NUM_DIGITS && digit) begin
      num_value = num_value * 10 + int'(b - ksp_pkg::CHAR_ZERO);
      if (num_value > ksp_pkg::DELAY_MAX) num_value = ksp_pkg::DELAY_MAX;
    end
  endfunction

  function void note_beat(logic [7:0] b, logic eos);
    bit line_end;
    int unsigned v;
    line_end = eos || b == ksp_pkg::CHAR_LF;
    if (!eos && b == ksp_pkg::CHAR_CR) return;
    step_q.delete();
    case (mode)
      PM_FIRST: begin
        if (line_end) begin
          press_word();
        end else if (b == ksp_pkg::CHAR_SPACE) begin
          if (word_is("STRING")) mode = PM_TYPE;
          else if (word_is("DELAY")) start_number(PM_DELAY);
          else if (word_is("DEFAULTDELAY")) start_number(PM_DEFDELAY);
          else if (word_is("REM")) mode = PM_REM;
          else begin
            press_with_gap();
            mode = PM_KEYS;
          end
          clear_word();
        end else begin
          add_char(b);
        end
      end
      PM_KEYS: begin
        if (line_end) begin
          if (word_len > 0 || word_ovf) press_with_gap();
        end else if (b == ksp_pkg::CHAR_SPACE) begin
          press_with_gap();
          clear_word();
        end else begin
          add_char(b);
        end
      end
      PM_TYPE: begin
        if (!line_end) push(ksp_pkg::ACT_TYPE_CHAR, b, 5'd0, 16'd0);
      end
      PM_DELAY, PM_DEFDELAY: begin
        if (line_end) begin
          v = num_neg ? 0 : num_value;
          push(mode == PM_DELAY ? ksp_pkg::ACT_WAIT : ksp_pkg::ACT_SET_DEFAULT_DELAY,
               8'd0, 5'd0, v[15:0]);
        end else begin
          digest_number(b);
        end
      end
      default: ;
    endcase
    if (line_end) begin
      push(ksp_pkg::ACT_RELEASE_ALL, 8'd0, 5'd0, 16'd0);
      mode = PM_FIRST;
      clear_word();
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  function void check_action(ksp_pkg::result_t got);
    ksp_pkg::result_t exp;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected beat: act=%0d chr=%0d key=%0d ms=%0d last=%0d",
                 got.action, got.char_code, got.named_key, got.delay_ms, got.last);
      return;
    end
    exp = expected_q.pop_front();
    if (got.action != exp.action || got.char_code != exp.char_code ||
        got.named_key != exp.named_key || got.delay_ms != exp.delay_ms ||
        got.last != exp.last) begin
      errors++;
      if (errors <= 10)
        $display({"mismatch: exp act=%0d chr=%0d key=%0d ms=%0d last=%0d,",
                  " got act=%0d chr=%0d key=%0d ms=%0d last=%0d"},
                 exp.action, exp.char_code, exp.named_key, exp.delay_ms, exp.last,
                 got.action, got.char_code, got.named_key, got.delay_ms, got.last);
    end
  endfunction
endclass

module tb_keystroke_script_parser;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BEATS = 65;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_script_byte;
  logic        in_end_of_script;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_action;
  logic [7:0]  out_char_code;
  logic [4:0]  out_named_key;
  logic [15:0] out_delay_ms;
  logic        out_last;

  action_scoreboard sb;
  ksp_pkg::result_t seen;
  logic [7:0]       line_bytes[$];
  bit               no_idle = 0;
  int               beats_sent = 0;
  int               cycle_cnt = 0;
  int               ready_hold = 0;

  keystroke_script_parser #(.WORD_CHARS(PARSER_WORD_CHARS)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_script_byte   (in_script_byte),
    .in_end_of_script (in_end_of_script),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_action       (out_action),
    .out_char_code    (out_char_code),
    .out_named_key    (out_named_key),
    .out_delay_ms     (out_delay_ms),
    .out_last         (out_last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_keystroke_script_parser NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen.action = out_action;
        seen.char_code = out_char_code;
        seen.named_key = out_named_key;
        seen.delay_ms = out_delay_ms;
        seen.last = out_last;
        sb.check_action(seen);
      end
      if (in_valid && in_ready) sb.note_beat(in_script_byte, in_end_of_script);
    end
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  initial begin
    int gap;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (ready_hold > 0) begin
        ready_hold--;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else if (out_ready) begin
        gap = rand_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          ready_hold = gap - 1;
        end
      end else begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(0, 6);
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic eos);
    int gap;
    in_valid <= 1'b1;
    in_script_byte <= b;
    in_end_of_script <= eos;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    @(negedge clk);
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_gap(input logic [7:0] v);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.gap_ms = v;
  endtask

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endfunction

  function automatic void add_letters(int n);
    repeat (n) line_bytes.push_back(8'd65 + 8'($urandom_range(0, 25)));
  endfunction

  function automatic void add_token();
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      add_str(sb.key_names[$urandom_range(0, sb.key_names.size() - 1)]);
    end else if (r == 4) begin
      do c = 8'($urandom_range(0, 255));
      while (c == ksp_pkg::CHAR_SPACE || c == ksp_pkg::CHAR_LF);
      line_bytes.push_back(c);
    end else if (r == 5) begin
      add_letters($urandom_range(2, 8));
    end else if (r == 6) begin
      add_letters($urandom_range(PARSER_WORD_CHARS + 1, PARSER_WORD_CHARS + 4));
    end else if (r == 7) begin
      add_letters(PARSER_WORD_CHARS);
    end else if (r == 9) begin
      add_str("REM");
    end
  endfunction

  function automatic void add_number();
    int n;
    int r;
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0: line_bytes.push_back(ksp_pkg::CHAR_TAB);
        1: line_bytes.push_back(ksp_pkg::CHAR_VT);
        2: line_bytes.push_back(ksp_pkg::CHAR_FF);
        default: line_bytes.push_back(ksp_pkg::CHAR_SPACE);
      endcase
    end
    r = $urandom_range(0, 5);
    if (r == 0) line_bytes.push_back(ksp_pkg::CHAR_MINUS);
    else if (r == 1) line_bytes.push_back(ksp_pkg::CHAR_PLUS);
    r = $urandom_range(0, 9);
    n = (r == 0) ? 0 : (r < 8) ? $urandom_range(1, 5) : $urandom_range(6, 8);
    repeat (n) line_bytes.push_back(ksp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 4) == 0) begin
      line_bytes.push_back(8'($urandom_range(0, 255)));
      line_bytes.push_back(ksp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
  endfunction

  function automatic void gen_random_line();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      n = $urandom_range(1, 4);
      for (int t = 0; t < n; t++) begin
        if (t > 0) line_bytes.push_back(ksp_pkg::CHAR_SPACE);
        add_token();
      end
      if ($urandom_range(0, 4) == 0) line_bytes.push_back(ksp_pkg::CHAR_SPACE);
    end else if (kind < 45) begin
      add_str("STRING ");
      repeat ($urandom_range(0, 6)) line_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 60) begin
      add_str("DELAY ");
      add_number();
    end else if (kind < 70) begin
      add_str("DEFAULTDELAY ");
      add_number();
    end else if (kind < 75) begin
      add_str("REM ");
      repeat ($urandom_range(0, 5)) line_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 85) begin
      add_token();
    end else if (kind < 95) begin
      repeat ($urandom_range(1, 8)) line_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_line(input bit noisy);
    foreach (line_bytes[i]) begin
      if (noisy && $urandom_range(0, 19) == 0) send_beat(ksp_pkg::CHAR_CR, 1'b0);
      send_beat(line_bytes[i], 1'b0);
    end
    if (noisy && $urandom_range(0, 24) == 0) send_beat(8'($urandom_range(0, 255)), 1'b1);
    else send_beat(ksp_pkg::CHAR_LF, 1'b0);
    line_bytes.delete();
  endtask

  initial begin
    int goal;
    logic [7:0] gaps [4];
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'd0;
    in_valid = 1'b0;
    in_script_byte = 8'd0;
    in_end_of_script = 1'b0;
    sb = new();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed lines at the reset gap
    send_line(0);
    add_str("ENTER");
    send_line(0);
    add_str("STRING Hi!");
    send_line(0);
    add_str("DELAY ");
    line_bytes.push_back(ksp_pkg::CHAR_TAB);
    add_str("-250");
    send_line(0);
    add_str("DEFAULTDELAY +70000x9");
    send_line(0);
    add_str("REM note");
    send_line(0);
    add_str("CTRL  q ");
    send_line(0);
    add_str("ABCDEFGHIJKLM NOPE F12");
    send_line(0);
    line_bytes.push_back(8'h00);
    line_bytes.push_back(ksp_pkg::CHAR_SPACE);
    line_bytes.push_back(ksp_pkg::CHAR_CR);
    line_bytes.push_back(8'hFF);
    send_line(0);
    // end of script right after a newline, carriage return byte ignored
    send_beat(ksp_pkg::CHAR_CR, 1'b1);

    gaps[0] = 8'd0;
    gaps[1] = 8'd255;
    gaps[2] = 8'($urandom_range(1, 254));
    gaps[3] = 8'($urandom_range(0, 255));
    for (int p = 0; p < 4; p++) begin
      settle_idle();
      write_gap(gaps[p]);
      no_idle = (p == 2);
      goal = beats_sent + PHASE_BEATS;
      while (beats_sent < goal) begin
        gen_random_line();
        send_line(1);
        if ($urandom_range(0, 29) == 0) settle_idle();
      end
    end
    no_idle = 0;
    settle_idle();
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_keystroke_script_parser OK");
    end else begin
      $display("tb_keystroke_script_parser NOT OK");
    end
    $finish;
  end

endmodule
